FILE: rtl/isct_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package isct_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int ADDR_W        = 64;
    localparam int CONF_W        = 2;

    localparam logic [CONF_W-1:0] CONF_MAX     = 2'd3;
    localparam logic [CONF_W-1:0] CONF_TRAINED = 2'd2;
    localparam logic [CONF_W-1:0] CONF_NEW     = 2'd1;
    localparam logic [CONF_W-1:0] CONF_EMPTY   = 2'd0;

    typedef logic [1:0] mode_t;
    localparam mode_t MODE_OBSERVE = 2'd0;
    localparam mode_t MODE_QUERY   = 2'd1;
    localparam mode_t MODE_CLEAR   = 2'd2;

    typedef struct packed {
        logic capture;
        logic execute;
    } isct_cmd_t;

    typedef struct packed {
        logic                     confident;
        logic signed [ADDR_W-1:0] stride_out;
        logic                     trigger;
    } isct_out_t;

endpackage

`default_nettype wire

FILE: rtl/isct_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module isct_ctrl
    import isct_pkg::*;
(
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_tvalid,
    output logic           s_tready,
    output logic           m_tvalid,
    input  wire logic      m_tready,
    output isct_cmd_t      cmd
);

    typedef enum logic [1:0] {
        ST_IDLE   = 2'b01,
        ST_UPDATE = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   slot_free;

    assign slot_free = !out_valid_reg || m_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign m_tvalid  = out_valid_reg;

    always_comb begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                if (slot_free) begin
                    cmd.execute    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/isct_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module isct_dp
    import isct_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire isct_cmd_t         cmd,
    input  wire mode_t             in_mode,
    input  wire logic [ADDR_W-1:0] in_pc,
    input  wire logic [ADDR_W-1:0] in_addr,
    output isct_out_t              result
);

    // table state
    logic [ADDR_W-1:0] tag_reg    [TABLE_ENTRIES];
    logic [ADDR_W-1:0] last_reg   [TABLE_ENTRIES];
    logic [ADDR_W-1:0] stride_reg [TABLE_ENTRIES];
    logic [CONF_W-1:0] conf_reg   [TABLE_ENTRIES];
    logic [IDX_W-1:0]  rank_reg   [TABLE_ENTRIES];

    // captured item and match vectors
    mode_t              mode_reg;
    logic [ADDR_W-1:0]  addr_reg;
    logic [ADDR_W-1:0]  pc_reg;
    logic [TABLE_ENTRIES-1:0] hit_vec_reg, same_vec_reg, low_vec_reg, oldest_vec_reg;
    logic               conf3_reg;

    logic [TABLE_ENTRIES-1:0] hit_vec_next, same_vec_next, low_vec_next, oldest_vec_next;
    logic               conf3_next;

    isct_out_t          result_reg;

    // match stage
    always_comb begin
        conf3_next = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            same_vec_next[i]   = (tag_reg[i] == in_pc);
            hit_vec_next[i]    = same_vec_next[i] && (conf_reg[i] != CONF_EMPTY);
            oldest_vec_next[i] = (rank_reg[i] == '0);
            if (same_vec_next[i] && conf_reg[i] == CONF_MAX) begin
                conf3_next = 1'b1;
            end
            low_vec_next[i] = (conf_reg[i] < CONF_TRAINED);
            for (int j = 0; j < TABLE_ENTRIES; j++) begin
                if (j != i && conf_reg[j] < CONF_TRAINED && rank_reg[j] < rank_reg[i]) begin
                    low_vec_next[i] = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            mode_reg       <= in_mode;
            pc_reg         <= in_pc;
            addr_reg       <= in_addr;
            hit_vec_reg    <= hit_vec_next;
            same_vec_reg   <= same_vec_next;
            low_vec_reg    <= low_vec_next;
            oldest_vec_reg <= oldest_vec_next;
            conf3_reg      <= conf3_next;
        end
    end

    // update stage
    logic [IDX_W-1:0]  hit_idx, same_idx, low_idx, oldest_idx, victim_idx, target_idx;
    logic              hit_any;
    logic [CONF_W-1:0] old_conf, new_conf;
    logic [ADDR_W-1:0] old_stride, old_last, now_stride;
    logic [IDX_W-1:0]  target_rank;
    logic              fire;

    always_comb begin
        hit_idx    = '0;
        same_idx   = '0;
        low_idx    = '0;
        oldest_idx = '0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (hit_vec_reg[i])    hit_idx    = IDX_W'(i);
            if (same_vec_reg[i])   same_idx   = IDX_W'(i);
            if (low_vec_reg[i])    low_idx    = IDX_W'(i);
            if (oldest_vec_reg[i]) oldest_idx = IDX_W'(i);
        end
        hit_any = |hit_vec_reg;
        if (|same_vec_reg) begin
            victim_idx = same_idx;
        end else if (|low_vec_reg) begin
            victim_idx = low_idx;
        end else begin
            victim_idx = oldest_idx;
        end
        target_idx  = hit_any ? hit_idx : victim_idx;
        target_rank = rank_reg[target_idx];

        old_conf   = conf_reg[hit_idx];
        old_stride = stride_reg[hit_idx];
        old_last   = last_reg[hit_idx];
        now_stride = addr_reg - old_last;
        fire = (old_conf >= CONF_TRAINED) && (old_stride != '0) &&
               ((old_stride == now_stride) || (old_conf == CONF_MAX && now_stride != '0));

        if (old_conf == CONF_NEW) begin
            new_conf = CONF_TRAINED;
        end else if (now_stride == old_stride) begin
            new_conf = (old_conf < CONF_MAX) ? old_conf + CONF_NEW : old_conf;
        end else begin
            new_conf = (old_conf > CONF_EMPTY) ? old_conf - CONF_NEW : CONF_EMPTY;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (cmd.execute && mode_reg == MODE_CLEAR)) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                tag_reg[i]    <= '0;
                last_reg[i]   <= '0;
                stride_reg[i] <= '0;
                conf_reg[i]   <= CONF_EMPTY;
                rank_reg[i]   <= IDX_W'(i);
            end
        end else if (cmd.execute && mode_reg == MODE_OBSERVE) begin
            for (int i = 0; i < TABLE_ENTRIES; i++) begin
                if (IDX_W'(i) == target_idx) begin
                    rank_reg[i] <= IDX_W'(TABLE_ENTRIES - 1);
                    if (hit_any) begin
                        if (now_stride != '0) begin
                            last_reg[i] <= addr_reg;
                            conf_reg[i] <= new_conf;
                            if (old_conf == CONF_NEW) begin
                                stride_reg[i] <= now_stride;
                            end
                        end
                    end else begin
                        tag_reg[i]  <= pc_reg;
                        last_reg[i] <= addr_reg;
                        conf_reg[i] <= CONF_NEW;
                    end
                end else if (rank_reg[i] > target_rank) begin
                    rank_reg[i] <= rank_reg[i] - IDX_W'(1);
                end
            end
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (cmd.execute) begin
            result_reg.trigger    <= (mode_reg == MODE_OBSERVE) && hit_any && fire;
            result_reg.stride_out <= ((mode_reg == MODE_OBSERVE) && hit_any && fire)
                                     ? old_stride : '0;
            result_reg.confident  <= (mode_reg == MODE_QUERY) && conf3_reg;
        end
    end

    assign result = result_reg;

endmodule

`default_nettype wire

FILE: rtl/ip_stride_confidence_table.sv
// ip_stride_confidence_table
// fully associative stride table with 2-bit confidence and exact lru ranks
// input channel s_*: one beat per request, s_tuser carries the mode
//   (observe access, confidence query, clear), s_tdata carries pc and addr
// result channel m_*: exactly one result beat per input beat, in order,
//   holding the trigger flag, the stored stride and the query answer
// schedule: the input beat is taken in the idle state and its result is registered
//   when the update state executes; no new beat is taken until that update is done;
//   the idle state does the parallel tag compare and lru search, the update state
//   the read-modify-write of the entry and its rank update
// stall: a result waits in the output register while m_tready is low; the
//   next input beat is still taken and its update holds until the slot frees
// reset: aresetn low clears tags, addresses, strides and confidence, sets
//   entry i to lru rank i and empties the output register; a clear request
//   restores the same table state in its update step
`timescale 1ns / 1ps
`default_nettype none

module ip_stride_confidence_table
    import isct_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // pc[63:0], addr[127:64]
    input  wire logic [1:0]   s_tuser,   // mode[1:0]
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [71:0]       m_tdata    // trigger[0], stride_out[64:1], confident[65]
);

    isct_cmd_t cmd;
    isct_out_t result;

    isct_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    isct_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .in_mode (s_tuser),
        .in_pc   (s_tdata[63:0]),
        .in_addr (s_tdata[127:64]),
        .result  (result)
    );

    assign m_tdata = {6'b0, result.confident, result.stride_out, result.trigger};

endmodule

`default_nettype wire

FILE: tb/sv/tb_ip_stride_confidence_table.sv
`timescale 1ns / 1ps

module tb_ip_stride_confidence_table;
    import isct_pkg::*;

    localparam mode_t MODE_UNUSED = 2'd3;
    localparam int    POOL_MAX    = 32;

    typedef enum int {RX_STREAM, RX_COIN, RX_CHOKE} rx_style_t;

    logic         aclk     = 1'b0;
    logic         aresetn  = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [127:0] s_tdata  = '0;
    logic [1:0]   s_tuser  = MODE_OBSERVE;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [71:0]  m_tdata;

    ip_stride_confidence_table u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),    // pc[63:0], addr[127:64]
        .s_tuser  (s_tuser),    // mode[1:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)     // trigger[0], stride_out[64:1], confident[65]
    );

    always #5 aclk = ~aclk;

    // shadow copy of the stride table
    logic [63:0] tbl_tag    [TABLE_ENTRIES];
    logic [63:0] tbl_last   [TABLE_ENTRIES];
    logic [63:0] tbl_stride [TABLE_ENTRIES];
    logic [1:0]  tbl_conf   [TABLE_ENTRIES];
    int          tbl_rank   [TABLE_ENTRIES];

    isct_out_t   stride_verdicts[$];
    isct_out_t   want_beat;
    isct_out_t   got_beat;

    int fail_count  = 0;
    int burst_left  = 0;
    int idle_gap    = 0;
    int n_observe   = 0;
    int n_query     = 0;
    int n_clear     = 0;
    int n_triggers  = 0;
    int n_confident = 0;

    rx_style_t rx_style = RX_STREAM;
    int        rx_left  = 0;

    logic [63:0] pool_pc     [POOL_MAX];
    logic [63:0] pool_addr   [POOL_MAX];
    logic [63:0] pool_stride [POOL_MAX];

    function automatic void clear_table();
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            tbl_tag[i]    = '0;
            tbl_last[i]   = '0;
            tbl_stride[i] = '0;
            tbl_conf[i]   = CONF_EMPTY;
            tbl_rank[i]   = i;
        end
    endfunction

    function automatic void make_most_recent(int idx);
        int old_rank;
        old_rank = tbl_rank[idx];
        for (int j = 0; j < TABLE_ENTRIES; j++) begin
            if (tbl_rank[j] > old_rank) tbl_rank[j]--;
        end
        tbl_rank[idx] = TABLE_ENTRIES - 1;
    endfunction

    function automatic isct_out_t predict_table(mode_t mode, logic [63:0] pc,
                                                logic [63:0] addr);
        isct_out_t   res;
        int          hit, same, low, oldest, low_rank, victim;
        logic [1:0]  conf;
        logic [63:0] old_stride, now_stride;
        logic        fire;
        res = '0;
        case (mode)
            MODE_QUERY: begin
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_conf[i] == CONF_MAX && tbl_tag[i] == pc) res.confident = 1'b1;
                end
            end
            MODE_CLEAR: begin
                clear_table();
            end
            MODE_OBSERVE: begin
                hit = -1;
                for (int i = 0; i < TABLE_ENTRIES; i++) begin
                    if (tbl_conf[i] != CONF_EMPTY && tbl_tag[i] == pc) hit = i;
                end
                if (hit >= 0) begin
                    conf       = tbl_conf[hit];
                    old_stride = tbl_stride[hit];
                    now_stride = addr - tbl_last[hit];
                    fire = conf >= CONF_TRAINED && old_stride != 0 &&
                           (old_stride == now_stride || (conf == CONF_MAX && now_stride != 0));
                    if (fire) begin
                        res.trigger    = 1'b1;
                        res.stride_out = old_stride;
                    end
                    if (now_stride != 0) begin
                        tbl_last[hit] = addr;
                        if (conf == CONF_NEW) begin
                            tbl_conf[hit]   = CONF_TRAINED;
                            tbl_stride[hit] = now_stride;
                        end else if (now_stride == old_stride) begin
                            if (conf != CONF_MAX) tbl_conf[hit] = conf + 2'd1;
                        end else if (conf != CONF_EMPTY) begin
                            tbl_conf[hit] = conf - 2'd1;
                        end
                    end
                    make_most_recent(hit);
                end else begin
                    same     = -1;
                    low      = -1;
                    oldest   = -1;
                    low_rank = TABLE_ENTRIES;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (tbl_conf[i] < CONF_TRAINED && tbl_rank[i] < low_rank) begin
                            low      = i;
                            low_rank = tbl_rank[i];
                        end
                        if (tbl_tag[i] == pc) same = i;
                        if (tbl_rank[i] == 0) oldest = i;
                    end
                    if (same >= 0) victim = same;
                    else if (low >= 0) victim = low;
                    else if (oldest >= 0) victim = oldest;
                    else victim = 0;
                    tbl_tag[victim]  = pc;
                    tbl_last[victim] = addr;
                    tbl_conf[victim] = CONF_NEW;
                    make_most_recent(victim);
                end
            end
            default: begin
            end
        endcase
        return res;
    endfunction

    function automatic logic [63:0] pick_stride();
        case ($urandom_range(0, 3))
            0: return 64'(8 * $urandom_range(1, 64));
            1: return 64'd0 - 64'(8 * $urandom_range(1, 64));
            2: return {$urandom, $urandom};
            default: return 64'($urandom_range(1, 4));
        endcase
    endfunction

    task automatic send_beat(input mode_t mode, input logic [63:0] pc, input logic [63:0] addr);
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {addr, pc};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        stride_verdicts.insert(stride_verdicts.size(), predict_table(mode, pc, addr));
        case (mode)
            MODE_OBSERVE: n_observe++;
            MODE_QUERY:   n_query++;
            MODE_CLEAR:   n_clear++;
            default: ;
        endcase
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                idle_gap   = 0;
                burst_left = $urandom_range(30, 120);
            end else begin
                idle_gap   = $urandom_range(1, 5);
                burst_left = $urandom_range(0, 12);
            end
            if (idle_gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (idle_gap) @(posedge aclk);
            end
        end
    endtask

    // hold the sender until the table has answered everything
    task automatic wait_for_answers();
        s_tvalid <= 1'b0;
        while (stride_verdicts.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic test_empty_table();
        send_beat(MODE_QUERY, 64'd0, 64'd0);
        send_beat(MODE_QUERY, '1, '1);
        send_beat(MODE_UNUSED, '1, '1);
        send_beat(MODE_OBSERVE, 64'd0, 64'd0);
        send_beat(MODE_OBSERVE, 64'd0, 64'd0);
        send_beat(MODE_CLEAR, '1, '1);
    endtask

    task automatic test_stride_training();
        logic [63:0] pc, base, step;
        pc   = 64'hffff_8000_0040_1000;
        base = 64'h0000_1000_0000_0000;
        step = 64'h40;
        send_beat(MODE_OBSERVE, pc, base);
        send_beat(MODE_OBSERVE, pc, base + step);
        send_beat(MODE_OBSERVE, pc, base + 2 * step);
        send_beat(MODE_OBSERVE, pc, base + 3 * step);
        send_beat(MODE_OBSERVE, pc, base + 3 * step);
        send_beat(MODE_OBSERVE, pc, base + 4 * step + 8);
        send_beat(MODE_OBSERVE, pc, base + 5 * step + 8);
        send_beat(MODE_QUERY, pc, 64'd0);
    endtask

    task automatic test_address_wrap();
        send_beat(MODE_OBSERVE, '1, 64'h10);
        send_beat(MODE_OBSERVE, '1, 64'hffff_ffff_ffff_fff0);
        send_beat(MODE_OBSERVE, '1, 64'hffff_ffff_ffff_ffd0);
        send_beat(MODE_OBSERVE, '1, 64'hffff_ffff_ffff_ffb0);
        send_beat(MODE_QUERY, '1, '1);
    endtask

    task automatic test_clear_state();
        send_beat(MODE_CLEAR, 64'd0, 64'd0);
        send_beat(MODE_QUERY, '1, 64'd0);
        send_beat(MODE_OBSERVE, 64'hffff_8000_0040_1000, 64'h0000_1000_0000_0100);
    endtask

    // load streams from a pool of pcs, mostly steady strides with some noise
    task automatic test_random_streams(input int pool_size, input int beats);
        int k, pick;
        for (k = 0; k < pool_size; k++) begin
            pool_pc[k]     = {$urandom, $urandom};
            pool_addr[k]   = {$urandom, $urandom};
            pool_stride[k] = pick_stride();
        end
        repeat (beats) begin
            k    = $urandom_range(0, pool_size - 1);
            pick = $urandom_range(0, 99);
            if (pick < 2) begin
                send_beat(MODE_CLEAR, {$urandom, $urandom}, {$urandom, $urandom});
            end else if (pick < 4) begin
                send_beat(MODE_UNUSED, {$urandom, $urandom}, {$urandom, $urandom});
            end else if (pick < 14) begin
                send_beat(MODE_QUERY, ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                                                    : pool_pc[k],
                          {$urandom, $urandom});
            end else if (pick < 19) begin
                send_beat(MODE_OBSERVE, ($urandom_range(0, 1) == 0) ? {$urandom, $urandom}
                                                                     : pool_pc[k],
                          {$urandom, $urandom});
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 7) pool_stride[k] = pick_stride();
                else if (pick < 10) pool_addr[k] = {$urandom, $urandom};
                if (pick < 7 || pick >= 15) pool_addr[k] = pool_addr[k] + pool_stride[k];
                send_beat(MODE_OBSERVE, pool_pc[k], pool_addr[k]);
            end
        end
    endtask

    always @(posedge aclk) begin
        if (rx_left == 0) begin
            rx_style = rx_style_t'($urandom_range(0, 2));
            rx_left  = $urandom_range(20, 150);
        end
        rx_left--;
        case (rx_style)
            RX_STREAM: m_tready <= 1'b1;
            RX_COIN:   m_tready <= ($urandom_range(0, 1) == 1);
            default:   m_tready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (stride_verdicts.size() == 0) begin
                $error("result beat with nothing outstanding: %h", m_tdata);
                fail_count++;
            end else begin
                want_beat = stride_verdicts.pop_front();
                got_beat  = isct_out_t'(m_tdata[65:0]);
                if (got_beat.trigger) n_triggers++;
                if (got_beat.confident) n_confident++;
                if (got_beat.trigger !== want_beat.trigger) begin
                    $error("trigger: expected %0d, got %0d", want_beat.trigger, got_beat.trigger);
                    fail_count++;
                end
                if (got_beat.stride_out !== want_beat.stride_out) begin
                    $error("stride_out: expected %h, got %h",
                           want_beat.stride_out, got_beat.stride_out);
                    fail_count++;
                end
                if (got_beat.confident !== want_beat.confident) begin
                    $error("confident: expected %0d, got %0d",
                           want_beat.confident, got_beat.confident);
                    fail_count++;
                end
            end
        end
    end

    initial begin
        #3_000_000;
        $display("** ip_stride_confidence_table: FAILED **");
        $finish;
    end

    initial begin
        clear_table();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_stride_training();
        test_address_wrap();
        test_clear_state();
        wait_for_answers();

        test_random_streams(3, 250);
        test_random_streams(8, 300);
        wait_for_answers();
        test_random_streams(16, 300);
        test_random_streams(20, 300);
        wait_for_answers();
        test_random_streams(28, 300);
        test_random_streams(12, 250);
        wait_for_answers();

        $display("run covered %0d observes with %0d prefetch triggers, %0d queries",
                 n_observe, n_triggers, n_query);
        $display("with %0d confident answers and %0d table clears, under random stalls",
                 n_confident, n_clear);
        if (fail_count == 0 && stride_verdicts.size() == 0) begin
            $display("** ip_stride_confidence_table: PASSED **");
        end else begin
            $display("** ip_stride_confidence_table: FAILED **");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/isct_pkg.sv
rtl/isct_ctrl.sv
rtl/isct_dp.sv
rtl/ip_stride_confidence_table.sv
tb/sv/tb_ip_stride_confidence_table.sv
